// ===== hw/rtl/spiking_neuron_update_with_traces_macros.svh =====
// Assertion macros shared by the checker of the spiking neuron update block.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef SPIKING_NEURON_UPDATE_WITH_TRACES_MACROS_SVH
`define SPIKING_NEURON_UPDATE_WITH_TRACES_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SNU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("snu_checker: assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define SNU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("snu_checker: assertion failed");

// Next-cycle implication that is also checked across reset.
`define SNU_ASSERT_NXT_ALL(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("snu_checker: assertion failed");

`endif

// ===== hw/rtl/snu_pkg.sv =====
// Shared types, constants and helper functions of the spiking neuron update block.
// Has no dependencies; every RTL module imports it.
`default_nettype none

package snu_pkg;

    // Default size of the neuron bank.
    localparam int NEURONS_DEF = 64;

    // Number of pipeline positions between the state read and the write-back.
    localparam int SNU_STAGES = 10;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRE_THRESHOLD = 3'd0,
        CFG_RESET_VOLTAGE  = 3'd1,
        CFG_RECOVERY_RATE  = 3'd2,
        CFG_RECOVERY_JUMP  = 3'd3,
        CFG_LTP_PEAK       = 3'd4,
        CFG_LTD_PEAK       = 3'd5,
        CFG_TRACE_DECAY    = 3'd6
    } t_cfg_reg;

    // Configuration reset values.
    localparam logic signed [15:0] RST_FIRE_THRESHOLD = 16'sd7680;
    localparam logic signed [15:0] RST_RESET_VOLTAGE  = -16'sd16640;
    localparam logic [15:0]        RST_RECOVERY_RATE  = 16'd1311;
    localparam logic [14:0]        RST_RECOVERY_JUMP  = 15'd1536;
    localparam logic [15:0]        RST_LTP_PEAK       = 16'd6554;
    localparam logic [15:0]        RST_LTD_PEAK       = 16'd7864;
    localparam logic [15:0]        RST_TRACE_DECAY    = 16'd62259;

    // Neuron state after reset: -65.0 and -13.0 in Q8.8.
    localparam logic signed [15:0] RST_MEMBRANE = -16'sd16640;
    localparam logic signed [15:0] RST_RECOVERY = -16'sd3328;

    // Model coefficients: 0.04 in Q0.16, 5, 140 in Q8.8, 0.2 in Q0.16.
    localparam logic [11:0]        K_SQUARE = 12'd2621;
    localparam logic signed [19:0] K_LINEAR = 20'sd5;
    localparam logic signed [19:0] K_OFFSET = 20'sd35840;
    localparam logic signed [31:0] K_RECOV  = 32'sd13107;

    // One input item.
    typedef struct packed {
        logic [5:0]         neuron_index;
        logic signed [15:0] input_current;
    } t_snu_in;

    // One result item.
    typedef struct packed {
        logic [5:0]         neuron_id;
        logic               fired;
        logic signed [15:0] membrane_out;
        logic [15:0]        ltp_trace_out;
        logic [15:0]        ltd_trace_out;
    } t_snu_out;

    // Configuration register file contents.
    typedef struct packed {
        logic signed [15:0] fire_threshold;
        logic signed [15:0] reset_voltage;
        logic [15:0]        recovery_rate;
        logic [14:0]        recovery_jump;
        logic [15:0]        ltp_peak;
        logic [15:0]        ltd_peak;
        logic [15:0]        trace_decay;
    } t_snu_cfg;

    // One word of the neuron state memory.
    typedef struct packed {
        logic signed [15:0] membrane;
        logic signed [15:0] recovery;
        logic [15:0]        ltp_trace;
        logic [15:0]        ltd_trace;
    } t_snu_state;

    localparam t_snu_state SNU_STATE_RESET = '{
        membrane:  RST_MEMBRANE,
        recovery:  RST_RECOVERY,
        ltp_trace: 16'd0,
        ltd_trace: 16'd0
    };

    // Result of the arithmetic pipeline for one neuron.
    typedef struct packed {
        logic       fired;
        t_snu_state nxt;
    } t_snu_calc;

    // Write request toward the state memory.
    typedef struct packed {
        logic       we;
        t_snu_state data;
    } t_snu_wr;

    // Clamp a wide signed value to 16 bits signed.
    function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
        logic signed [15:0] res;
        if (x > 24'sd32767) begin
            res = 16'sh7FFF;
        end else if (x < -24'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = x[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/snu_stream_if.sv =====
// Valid/ready stream channel used for the input and result channels.
// The payload type is a parameter; the types come from snu_pkg.
`default_nettype none

interface snu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/snu_cfg_regs.sv =====
// Configuration register file of the spiking neuron update block.
// Depends on snu_pkg for the register indexes, reset values and t_snu_cfg.
`default_nettype none

module snu_cfg_regs
    import snu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_snu_cfg                   o_cfg
);

    t_snu_cfg r_cfg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fire_threshold <= RST_FIRE_THRESHOLD;
            r_cfg.reset_voltage  <= RST_RESET_VOLTAGE;
            r_cfg.recovery_rate  <= RST_RECOVERY_RATE;
            r_cfg.recovery_jump  <= RST_RECOVERY_JUMP;
            r_cfg.ltp_peak       <= RST_LTP_PEAK;
            r_cfg.ltd_peak       <= RST_LTD_PEAK;
            r_cfg.trace_decay    <= RST_TRACE_DECAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRE_THRESHOLD: r_cfg.fire_threshold <= $signed(i_cfg_data);
                CFG_RESET_VOLTAGE:  r_cfg.reset_voltage  <= $signed(i_cfg_data);
                CFG_RECOVERY_RATE:  r_cfg.recovery_rate  <= i_cfg_data;
                CFG_RECOVERY_JUMP:  r_cfg.recovery_jump  <= i_cfg_data[14:0];
                CFG_LTP_PEAK:       r_cfg.ltp_peak       <= i_cfg_data;
                CFG_LTD_PEAK:       r_cfg.ltd_peak       <= i_cfg_data;
                CFG_TRACE_DECAY:    r_cfg.trace_decay    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/snu_state_mem.sv =====
// Per-neuron state memory: one synchronous RAM word per neuron with a
// registered read port, one write port and a clearing sweep after reset.
// Depends on snu_pkg for t_snu_state, t_snu_wr and the reset word.
`default_nettype none

module snu_state_mem
    import snu_pkg::*;
#(
    parameter int  NEURONS = NEURONS_DEF,
    localparam int AW      = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_snu_state         o_rdata,
    input  wire t_snu_wr       i_wr,
    input  wire logic [AW-1:0] i_waddr,
    output logic               o_busy
);

    t_snu_state    r_mem [NEURONS];
    t_snu_state    r_rdata;
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;

    // Clearing sweep: one entry per cycle from address zero upward.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(NEURONS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Write port shared by the sweep and the write-back, and the read port.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= SNU_STATE_RESET;
        end else if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

// ===== hw/rtl/snu_pipe.sv =====
// Arithmetic pipeline of the neuron update: spike check, two quadratic
// half steps, the recovery step and the trace decay, one position per enable.
// Depends on snu_pkg for the state and configuration types and sat16.
`default_nettype none

module snu_pipe
    import snu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [SNU_STAGES-1:0] i_en,
    input  wire logic signed [15:0]    i_cur,
    input  wire t_snu_state            i_rdata,
    input  wire t_snu_cfg              i_cfg,
    output t_snu_calc                  o_res
);

    // Linear part of a half step: 5*V + 140 - U + I.
    function automatic logic signed [19:0] lin_term(
        input logic signed [15:0] v,
        input logic signed [15:0] u,
        input logic signed [15:0] cur
    );
        logic signed [19:0] res;
        res = 20'(v) * K_LINEAR + K_OFFSET - 20'(u) + 20'(cur);
        return res;
    endfunction

    // Finish a half step: V + floor((square term + linear part) / 2), clamped.
    function automatic logic signed [15:0] half_fin(
        input logic signed [15:0] v,
        input logic [17:0]        qs,
        input logic signed [19:0] lin
    );
        logic signed [20:0] s;
        logic signed [23:0] sum;
        s   = 21'($signed({1'b0, qs})) + 21'(lin);
        sum = 24'(v) + 24'(s >>> 1);
        return sat16(sum);
    endfunction

    // Position 0: input current, aligned with the memory read data.
    logic signed [15:0] r0_cur;

    // Position 1: state after the spike check.
    logic signed [15:0] r1_v, r1_u, r1_cur;
    logic [15:0]        r1_tp, r1_td;
    logic               r1_fired;

    // Position 2: first square and linear part, trace products.
    logic signed [31:0] r2_sq;
    logic signed [19:0] r2_lin;
    logic signed [15:0] r2_v, r2_u, r2_cur;
    logic [15:0]        r2_tp, r2_td;
    logic               r2_fired;

    // Position 3: first scaled square.
    logic [17:0]        r3_qs;
    logic signed [19:0] r3_lin;
    logic signed [15:0] r3_v, r3_u, r3_cur;
    logic [15:0]        r3_tp, r3_td;
    logic               r3_fired;

    // Position 4: voltage after the first half step.
    logic signed [15:0] r4_v, r4_u, r4_cur;
    logic [15:0]        r4_tp, r4_td;
    logic               r4_fired;

    // Position 5: second square and linear part.
    logic signed [31:0] r5_sq;
    logic signed [19:0] r5_lin;
    logic signed [15:0] r5_v, r5_u;
    logic [15:0]        r5_tp, r5_td;
    logic               r5_fired;

    // Position 6: second scaled square.
    logic [17:0]        r6_qs;
    logic signed [19:0] r6_lin;
    logic signed [15:0] r6_v, r6_u;
    logic [15:0]        r6_tp, r6_td;
    logic               r6_fired;

    // Position 7: voltage after the second half step.
    logic signed [15:0] r7_v, r7_u;
    logic [15:0]        r7_tp, r7_td;
    logic               r7_fired;

    // Position 8: recovery drive 0.2*V - U in Q8.24.
    logic signed [32:0] r8_diff;
    logic signed [15:0] r8_v, r8_u;
    logic [15:0]        r8_tp, r8_td;
    logic               r8_fired;

    // Position 9: recovery increment.
    logic signed [17:0] r9_du;
    logic signed [15:0] r9_v, r9_u;
    logic [15:0]        r9_tp, r9_td;
    logic               r9_fired;

    // Combinational terms of each position.
    logic               fire;
    logic signed [15:0] u_jump;
    logic [31:0]        tp_prod, td_prod;
    logic [42:0]        q1, q2;
    logic signed [31:0] rec_m;
    logic signed [49:0] rec_prod;

    always_comb begin
        fire     = i_rdata.membrane >= i_cfg.fire_threshold;
        u_jump   = sat16(24'(i_rdata.recovery) + 24'($signed({1'b0, i_cfg.recovery_jump})));
        tp_prod  = 32'(r1_tp) * 32'(i_cfg.trace_decay);
        td_prod  = 32'(r1_td) * 32'(i_cfg.trace_decay);
        q1       = 43'(r2_sq[30:0]) * 43'(K_SQUARE);
        q2       = 43'(r5_sq[30:0]) * 43'(K_SQUARE);
        rec_m    = 32'(r7_v) * K_RECOV;
        rec_prod = 50'(r8_diff) * 50'($signed({1'b0, i_cfg.recovery_rate}));
    end

    // Position 0.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_cur <= i_cur;
        end
    end

    // Position 1: spike substitution.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_fired <= fire;
            r1_v     <= fire ? i_cfg.reset_voltage : i_rdata.membrane;
            r1_u     <= fire ? u_jump : i_rdata.recovery;
            r1_tp    <= fire ? i_cfg.ltp_peak : i_rdata.ltp_trace;
            r1_td    <= fire ? i_cfg.ltd_peak : i_rdata.ltd_trace;
            r1_cur   <= r0_cur;
        end
    end

    // Position 2: square of the voltage and trace decay.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_sq    <= 32'(r1_v) * 32'(r1_v);
            r2_lin   <= lin_term(r1_v, r1_u, r1_cur);
            r2_v     <= r1_v;
            r2_u     <= r1_u;
            r2_cur   <= r1_cur;
            r2_tp    <= tp_prod[31:16];
            r2_td    <= td_prod[31:16];
            r2_fired <= r1_fired;
        end
    end

    // Position 3: 0.04 * V^2.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_qs    <= q1[41:24];
            r3_lin   <= r2_lin;
            r3_v     <= r2_v;
            r3_u     <= r2_u;
            r3_cur   <= r2_cur;
            r3_tp    <= r2_tp;
            r3_td    <= r2_td;
            r3_fired <= r2_fired;
        end
    end

    // Position 4: first half step done.
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_v     <= half_fin(r3_v, r3_qs, r3_lin);
            r4_u     <= r3_u;
            r4_cur   <= r3_cur;
            r4_tp    <= r3_tp;
            r4_td    <= r3_td;
            r4_fired <= r3_fired;
        end
    end

    // Position 5: square of the intermediate voltage.
    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_sq    <= 32'(r4_v) * 32'(r4_v);
            r5_lin   <= lin_term(r4_v, r4_u, r4_cur);
            r5_v     <= r4_v;
            r5_u     <= r4_u;
            r5_tp    <= r4_tp;
            r5_td    <= r4_td;
            r5_fired <= r4_fired;
        end
    end

    // Position 6: 0.04 * V^2 again.
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_qs    <= q2[41:24];
            r6_lin   <= r5_lin;
            r6_v     <= r5_v;
            r6_u     <= r5_u;
            r6_tp    <= r5_tp;
            r6_td    <= r5_td;
            r6_fired <= r5_fired;
        end
    end

    // Position 7: second half step done.
    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r7_v     <= half_fin(r6_v, r6_qs, r6_lin);
            r7_u     <= r6_u;
            r7_tp    <= r6_tp;
            r7_td    <= r6_td;
            r7_fired <= r6_fired;
        end
    end

    // Position 8: 0.2 * V minus U, both scaled by 2^16.
    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r8_diff  <= 33'(rec_m) - (33'(r7_u) <<< 16);
            r8_v     <= r7_v;
            r8_u     <= r7_u;
            r8_tp    <= r7_tp;
            r8_td    <= r7_td;
            r8_fired <= r7_fired;
        end
    end

    // Position 9: scale by the recovery rate, floor of the 2^-32 part.
    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r9_du    <= rec_prod[49:32];
            r9_v     <= r8_v;
            r9_u     <= r8_u;
            r9_tp    <= r8_tp;
            r9_td    <= r8_td;
            r9_fired <= r8_fired;
        end
    end

    // Final recovery sum and result word.
    always_comb begin
        o_res.fired         = r9_fired;
        o_res.nxt.membrane  = r9_v;
        o_res.nxt.recovery  = sat16(24'(r9_u) + 24'(r9_du));
        o_res.nxt.ltp_trace = r9_tp;
        o_res.nxt.ltd_trace = r9_td;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spiking_neuron_update_with_traces.sv =====
// Spiking neuron update with potentiation and depression traces.
// Channels: i_in_ch carries one transaction per neuron step (neuron index and
// summed input current); o_out_ch returns exactly one result transaction per
// input, in input order. Configuration is written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write it only while no transaction
// is in flight, which the block itself does not enforce. A result passes the
// memory read with position 0, positions 1 to 9 and the output register.
// Throughput: one transaction per cycle as long as o_out_ch does not stall and
// no transaction names a neuron that is still in the pipeline. Such a
// transaction waits until that update is written back, because the state
// memory is read at acceptance and written at the end.
// Indexes outside the bank return zeros and leave the state alone.
// Reset: synchronous, active low. Afterwards the state memory is swept to its
// reset values, one neuron per cycle, and i_in_ch is not ready until the sweep
// is done; configuration writes are taken throughout.
// Stall: when o_out_ch is not ready, the result is held in the output
// register and the pipeline keeps accepting until its positions are full.
// Depends on snu_pkg, snu_stream_if, snu_cfg_regs, snu_state_mem, snu_pipe.
`default_nettype none

module spiking_neuron_update_with_traces
    import snu_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    snu_stream_if.sink                 i_in_ch,
    snu_stream_if.source               o_out_ch,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int LAST = SNU_STAGES - 1;

    t_snu_cfg   cfg;
    t_snu_state rdata;
    t_snu_calc  calc;
    t_snu_wr    wr;
    logic       mem_busy;

    // Per-position control: occupancy, index and range flag.
    logic [SNU_STAGES-1:0] r_vld;
    logic [SNU_STAGES-1:0] r_inr;
    logic [5:0]            r_idx [SNU_STAGES];
    logic                  r_out_vld;
    t_snu_out              r_out;

    logic [SNU_STAGES:0]   space;
    logic [SNU_STAGES-1:0] mov;
    logic [SNU_STAGES-1:0] en;
    logic                  hazard;
    logic                  in_inr;
    logic                  in_ready;
    logic                  accept;

    // Bubble-collapsing advance from the output register back to position 0.
    always_comb begin
        space[SNU_STAGES] = !r_out_vld || o_out_ch.ready;
        for (int k = LAST; k >= 0; k--) begin
            mov[k]   = r_vld[k] && space[k+1];
            space[k] = !r_vld[k] || mov[k];
        end
    end

    // Interlock: hold a transaction whose neuron is still being updated.
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < SNU_STAGES; k++) begin
            hazard = hazard ||
                     (r_vld[k] && r_inr[k] && (r_idx[k] == i_in_ch.data.neuron_index));
        end
    end

    assign in_inr         = 32'(i_in_ch.data.neuron_index) < NEURONS;
    assign in_ready       = space[0] && !mem_busy && !hazard;
    assign i_in_ch.ready  = in_ready;
    assign accept         = i_in_ch.valid && in_ready;

    // Load enables of the pipeline positions.
    always_comb begin
        en[0] = accept;
        for (int k = 1; k < SNU_STAGES; k++) begin
            en[k] = mov[k-1];
        end
    end

    // Occupancy bits and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            for (int k = 0; k < SNU_STAGES; k++) begin
                r_vld[k] <= en[k] || (r_vld[k] && !mov[k]);
            end
            if (mov[LAST]) begin
                r_out_vld <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Index and range flag travel with each transaction.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_idx[0] <= i_in_ch.data.neuron_index;
            r_inr[0] <= in_inr;
        end
        for (int k = 1; k < SNU_STAGES; k++) begin
            if (en[k]) begin
                r_idx[k] <= r_idx[k-1];
                r_inr[k] <= r_inr[k-1];
            end
        end
    end

    // Output register; out-of-range neurons report zeros.
    always_ff @(posedge i_clk) begin
        if (mov[LAST]) begin
            r_out.neuron_id <= r_idx[LAST];
            if (r_inr[LAST]) begin
                r_out.fired         <= calc.fired;
                r_out.membrane_out  <= calc.nxt.membrane;
                r_out.ltp_trace_out <= calc.nxt.ltp_trace;
                r_out.ltd_trace_out <= calc.nxt.ltd_trace;
            end else begin
                r_out.fired         <= 1'b0;
                r_out.membrane_out  <= '0;
                r_out.ltp_trace_out <= '0;
                r_out.ltd_trace_out <= '0;
            end
        end
    end

    assign o_out_ch.valid = r_out_vld;
    assign o_out_ch.data  = r_out;

    // Write-back of the updated state as the result leaves the pipeline.
    assign wr.we   = mov[LAST] && r_inr[LAST];
    assign wr.data = calc.nxt;

    snu_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    snu_state_mem #(
        .NEURONS (NEURONS)
    ) u_state_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept && in_inr),
        .i_raddr (AW'(i_in_ch.data.neuron_index)),
        .o_rdata (rdata),
        .i_wr    (wr),
        .i_waddr (AW'(r_idx[LAST])),
        .o_busy  (mem_busy)
    );

    snu_pipe u_pipe (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cur   (i_in_ch.data.input_current),
        .i_rdata (rdata),
        .i_cfg   (cfg),
        .o_res   (calc)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/snu_checker.sv =====
// Port-level checker of the spiking neuron update block and its bind.
// Depends on snu_pkg and the assertion macros header.
`default_nettype none

`include "spiking_neuron_update_with_traces_macros.svh"

module snu_checker
    import snu_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     i_in_ready,
    input wire logic     i_out_valid,
    input wire logic     i_out_ready,
    input wire t_snu_out i_out_data
);

    localparam int CNT_W = $clog2(SNU_STAGES + 3);

    logic [CNT_W-1:0] r_pending;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Transactions accepted whose results are not yet taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + CNT_W'(1);
        end else if (!in_acc && out_acc) begin
            r_pending <= r_pending - CNT_W'(1);
        end
    end

    // A result stays offered until it is taken.
    `SNU_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // The state sweep after reset keeps the input channel closed.
    `SNU_ASSERT_NXT_ALL(a_rst_closes_input, !i_rst_n, !i_in_ready)

    // Every result belongs to an accepted transaction.
    `SNU_ASSERT_IMP(a_no_invented, i_out_valid, r_pending != '0)

    // Neurons outside the bank report all zeros.
    `SNU_ASSERT_IMP(a_oob_zero, i_out_valid && (32'(i_out_data.neuron_id) >= NEURONS), !i_out_data.fired && (i_out_data.membrane_out == '0) && (i_out_data.ltp_trace_out == '0) && (i_out_data.ltd_trace_out == '0))

endmodule

bind spiking_neuron_update_with_traces snu_checker #(
    .NEURONS (NEURONS)
) u_snu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_data  (o_out_ch.data)
);

`default_nettype wire
